// ===== rtl/tpq_pkg.sv =====
// Package for the task priority queue: command codes, the stored entry,
// and the request, response and cell control structs.
// Depends on nothing; used by tpq_cell and task_priority_queue.
package tpq_pkg;

  localparam int unsigned TidW = 7;
  localparam int unsigned PriW = 8;
  localparam int unsigned OccW = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [TidW-1:0] tid;
    logic [PriW-1:0] pri;
  } entry_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [TidW-1:0] task_id;
    logic [PriW-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [TidW-1:0] result_task;
    logic            valid_res;
    logic            overflow;
    logic [OccW-1:0] occupancy;
  } rsp_t;

  // Broadcast from the controller to every cell in the chain.
  typedef struct packed {
    logic            ins_en;  // insert or rotate is placing bcast
    logic            rem_en;  // a remove closes the gap at the first match
    entry_t          bcast;
    logic [PriW-1:0] key;
    logic [TidW-1:0] tid;
  } cell_ctl_t;

endpackage

// ===== rtl/tpq_cell.sv =====
// One slot of the sorted chain: holds a task id and its priority and
// takes its next value from itself, a neighbor or the broadcast entry.
// Depends on tpq_pkg.
module tpq_cell (
  input  logic               clk_i,
  input  tpq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               at_count_i,
  input  logic               ge_prev_i,
  input  logic               shift_down_i,
  input  tpq_pkg::entry_t    lower_i,
  input  tpq_pkg::entry_t    upper_i,
  output tpq_pkg::entry_t    entry_o,
  output logic               ge_o,
  output logic               match_o
);

  tpq_pkg::entry_t entry_q, entry_d;

  assign ge_o    = occ_i && (entry_q.pri >= ctl_i.key);
  assign match_o = occ_i && (entry_q.tid == ctl_i.tid);
  assign entry_o = entry_q;

  // On insert, entries at or above the key move up one place; the lowest
  // of them (or the first free slot) takes the broadcast entry.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en) begin
      if (ge_prev_i) begin
        entry_d = lower_i;
      end else if (at_count_i || ge_o) begin
        entry_d = ctl_i.bcast;
      end
    end else if (ctl_i.rem_en && shift_down_i) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/task_priority_queue.sv =====
// Top level of the task priority queue: controller, count register and
// the chain of tpq_cell slots. Depends on tpq_pkg and tpq_cell.
//
// Usage: a command transfer happens at a rising edge where start_i is high
// and busy_o is low. busy_o is always low here, so a command may be issued
// in every cycle. The command is insert, pop head, remove named task or
// rotate head, carried in req_i.
// Every command finishes in the cycle it is taken. The result appears on
// rsp_o in the next cycle with done_o high for exactly that one cycle,
// and a new command can be taken in every cycle. The rate is set by the
// chain of cells: each cell compares its own priority or id against the
// broadcast key or task id and shifts to or from its neighbor in the same
// cycle, so a command needs one compare, one prefix and one register update.
// The receiver cannot hold results off; each result is taken at the edge
// that ends its done_o cycle.
// Slot 0 holds the lowest priority (newest among equals); slot count-1 is
// the head. Rotate is an insert of the head at its own priority, which the
// cells carry out with the same shift as an insert.
// Reset clears the count and the result strobe; the slot contents are not
// reset and are only read below the count.
module task_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tpq_pkg::req_t req_i,
  output logic          done_o,
  output tpq_pkg::rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  tpq_pkg::rsp_t   rsp_q, rsp_d;

  tpq_pkg::entry_t entry   [DEPTH];
  logic [DEPTH-1:0] occ, at_count, ge, match, prefix, head_sel, first_sel;
  tpq_pkg::entry_t  head;
  logic [tpq_pkg::TidW-1:0] found_tid;
  tpq_pkg::cell_ctl_t ctl;

  logic full, empty, any_match;
  logic do_ins, do_pop, do_rem, do_rot, ovf;
  logic [CntW+tpq_pkg::OccW-1:0] occ_wide;

  assign busy_o = 1'b0;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  // Per-slot occupancy and the head and first-match selectors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_sel
    assign occ[i]      = (CntW'(i) < count_q);
    assign at_count[i] = (CntW'(i) == count_q);
    if (i == DEPTH - 1) begin : g_top
      assign head_sel[i] = occ[i];
    end else begin : g_mid
      assign head_sel[i] = occ[i] && !occ[i+1];
    end
    if (i == 0) begin : g_first
      assign prefix[i]    = match[i];
      assign first_sel[i] = match[i];
    end else begin : g_rest
      assign prefix[i]    = prefix[i-1] | match[i];
      assign first_sel[i] = match[i] && !prefix[i-1];
    end
  end

  // One-hot selection of the head entry and the removed task.
  always_comb begin
    head      = '0;
    found_tid = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      head      = head | (head_sel[k] ? entry[k] : '0);
      found_tid = found_tid | (first_sel[k] ? entry[k].tid : '0);
    end
  end

  assign any_match = prefix[DEPTH-1];

  always_comb begin
    do_ins = 1'b0;
    do_pop = 1'b0;
    do_rem = 1'b0;
    do_rot = 1'b0;
    ovf    = 1'b0;
    if (start_i && !busy_o) begin
      unique case (req_i.cmd)
        tpq_pkg::CMD_INSERT: begin
          do_ins = !full;
          ovf    = full;
        end
        tpq_pkg::CMD_POP:    do_pop = !empty;
        tpq_pkg::CMD_REMOVE: do_rem = any_match;
        tpq_pkg::CMD_ROTATE: do_rot = !empty;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.ins_en = do_ins || do_rot;
    ctl.rem_en = do_rem;
    ctl.tid    = req_i.task_id;
    if (do_rot) begin
      ctl.bcast = head;
      ctl.key   = head.pri;
    end else begin
      ctl.bcast.tid = req_i.task_id;
      ctl.bcast.pri = req_i.priority_req;
      ctl.key       = req_i.priority_req;
    end
  end

  // The chain: each cell sees its lower and upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tpq_pkg::entry_t lower, upper;
    logic            ge_prev;
    if (i == 0) begin : g_lo
      assign lower   = '0;
      assign ge_prev = 1'b0;
    end else begin : g_lo_n
      assign lower   = entry[i-1];
      assign ge_prev = ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi_n
      assign upper = entry[i+1];
    end
    tpq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ[i]),
      .at_count_i  (at_count[i]),
      .ge_prev_i   (ge_prev),
      .shift_down_i(prefix[i]),
      .lower_i     (lower),
      .upper_i     (upper),
      .entry_o     (entry[i]),
      .ge_o        (ge[i]),
      .match_o     (match[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop || do_rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign occ_wide = (CntW + tpq_pkg::OccW)'(count_d);

  always_comb begin
    rsp_d.result_task = '0;
    rsp_d.valid_res   = 1'b0;
    if (do_pop || do_rot) begin
      rsp_d.result_task = head.tid;
      rsp_d.valid_res   = 1'b1;
    end else if (do_rem) begin
      rsp_d.result_task = found_tid;
      rsp_d.valid_res   = 1'b1;
    end
    rsp_d.overflow  = ovf;
    rsp_d.occupancy = occ_wide[tpq_pkg::OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  function automatic logic [tpq_pkg::OccW-1:0] occ_wide_q();
    logic [CntW+tpq_pkg::OccW-1:0] w;
    w = (CntW + tpq_pkg::OccW)'(count_q);
    return w[tpq_pkg::OccW-1:0];
  endfunction

  // The count never passes the number of slots.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("count exceeds depth");

  // Every accepted command gives exactly one result in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result strobe without a command");

  // A dropped insert only happens on a full queue and reports no task.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.overflow) |-> (!rsp_o.valid_res && $past(full)))
    else $error("overflow without a full queue");

  // The reported occupancy matches the count after the command.
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.occupancy == occ_wide_q()))
    else $error("occupancy does not match count");

endmodule
